>>> sv/vq_block_decoder_top_defines.svh
// Assertion macros for the VQ block decoder.
`ifndef VQ_BLOCK_DECODER_TOP_DEFINES_SVH
`define VQ_BLOCK_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VQBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("vqbd: sequential check failed");
`define VQBD_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("vqbd: combinational check failed");
`else
`define VQBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`define VQBD_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> sv/vqbd_pkg.sv
// Shared types and constants of the VQ block decoder.
`default_nettype none
package vqbd_pkg;

  localparam int unsigned CODEBOOK_WORDS_DEF  = 16384;
  localparam int unsigned FRAME_ADDR_BITS_DEF = 20;

  localparam int unsigned CA_W       = 18;
  localparam int unsigned BADDR_W    = 20;
  localparam int unsigned CB_ADDR_W  = 14;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned STRIDE_W   = 12;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [7:0] MARKER_4X2 = 8'd15;
  localparam logic [7:0] MARKER_4X4 = 8'd255;

  localparam logic REQ_CB_WRITE = 1'b0;
  localparam logic REQ_BLOCK    = 1'b1;

  typedef enum logic [1:0] {
    CFG_BLOCK_MODE,
    CFG_FRAME_COLS,
    CFG_BLOCK_ROWS,
    CFG_LINE_STRIDE
  } cfg_idx_t;

  typedef struct packed {
    logic                block_mode;
    logic [COUNT_W-1:0]  frame_cols;
    logic [COUNT_W-1:0]  block_rows;
    logic [STRIDE_W-1:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [BADDR_W-1:0] byte_addr;
    logic               last;
    logic               oor;
    logic               fill;
    logic [7:0]         fill_byte;
  } issue_t;

endpackage
`default_nettype wire

>>> sv/vq_block_decoder_top.sv
// Top level of the VQ block decoder: config registers and datapath.
//
// Input stream (in_*): one item per transfer. in_tuser[0] = 0 writes the
// codebook word in_tdata[45:14] at in_tdata[13:0]; 1 decodes a block whose
// index is {in_tdata[61:54], in_tdata[53:46]}.
// Result stream (out_*): one transfer per block row, 2 rows in 4x2 mode and
// 4 rows in 4x4 mode; out_tlast marks the final row, out_tuser[0] flags a
// codebook address beyond the store (word then zero).
// Config port (cfg_*): always ready; write only while the block is idle.
// The first row of a block passes the sequencer's row registers, the aligned
// read stage and the output register before out_tvalid rises for it.
// Throughput: one row per cycle from the single codebook read port while the
// receiver does not stall; intake waits for a block's last row to issue.
// Reset clears the frame position to the top-left block and loads default
// config; codebook contents are undefined until written.
// A stalled receiver holds the output register; the aligned read stage
// and then intake stall behind it, with no row lost.
`default_nettype none
`include "vq_block_decoder_top_defines.svh"
module vq_block_decoder_top
  import vqbd_pkg::*;
#(
  parameter int unsigned CODEBOOK_WORDS  = CODEBOOK_WORDS_DEF,
  parameter int unsigned FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [13:0] cb_addr, [45:14] cb_word, [53:46] index_low, [61:54] index_high
  input  wire logic [63:0]           in_tdata,
  // [0] req_type
  input  wire logic [0:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [19:0] byte_addr, [51:20] pixel_word
  output logic [55:0]                out_tdata,
  output logic                       out_tlast,
  // [0] out_of_range
  output logic [0:0]                 out_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(CODEBOOK_WORDS);

  cfg_t              cfg_r;
  issue_t            issue;
  logic              issue_ok;
  logic              mem_wr_en, mem_rd_en;
  logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
  logic [WORD_W-1:0] mem_wr_data, mem_rd_data;
  logic              in_blk_xfer, out_stall, out_oor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_mode  <= 1'b1;
      cfg_r.frame_cols  <= COUNT_W'(80);
      cfg_r.block_rows  <= COUNT_W'(50);
      cfg_r.line_stride <= STRIDE_W'(320);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLOCK_MODE:  cfg_r.block_mode  <= cfg_data[0];
        CFG_FRAME_COLS:  cfg_r.frame_cols  <= cfg_data[COUNT_W-1:0];
        CFG_BLOCK_ROWS:  cfg_r.block_rows  <= cfg_data[COUNT_W-1:0];
        CFG_LINE_STRIDE: cfg_r.line_stride <= cfg_data[STRIDE_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  vqbd_sequencer #(
    .CODEBOOK_WORDS  (CODEBOOK_WORDS),
    .FRAME_ADDR_BITS (FRAME_ADDR_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_req_type   (in_tuser[0]),
    .in_cb_addr    (in_tdata[13:0]),
    .in_cb_word    (in_tdata[45:14]),
    .in_index_low  (in_tdata[53:46]),
    .in_index_high (in_tdata[61:54]),
    .issue_ok      (issue_ok),
    .issue         (issue),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr)
  );

  vqbd_codebook_mem #(
    .DEPTH (CODEBOOK_WORDS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  vqbd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .rd_data    (mem_rd_data),
    .issue_ok   (issue_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  assign in_blk_xfer = in_tvalid && in_tready && (in_tuser[0] == REQ_BLOCK);
  assign out_stall   = out_tvalid && !out_tready;
  assign out_oor     = out_tvalid && out_tuser[0];

  `VQBD_ASSERT_NEXT(a_block_holds_intake, clk, rst_n, in_blk_xfer, !in_tready)
  `VQBD_ASSERT_NOW(a_oor_word_zero, clk, rst_n, out_oor, out_tdata[51:20] == 32'd0)
  `VQBD_ASSERT_NEXT(a_out_held, clk, rst_n, out_stall, out_tvalid)

endmodule
`default_nettype wire

>>> sv/vqbd_codebook_mem.sv
// Codebook memory: one write port, one registered read port.
`default_nettype none
module vqbd_codebook_mem
  import vqbd_pkg::*;
#(
  parameter int unsigned DEPTH = CODEBOOK_WORDS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WORD_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WORD_W-1:0]        rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> sv/vqbd_sequencer.sv
// Item intake, frame position tracking and per-row codebook read issue.
`default_nettype none
module vqbd_sequencer
  import vqbd_pkg::*;
#(
  parameter int unsigned CODEBOOK_WORDS  = CODEBOOK_WORDS_DEF,
  parameter int unsigned FRAME_ADDR_BITS = FRAME_ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cfg_t                              cfg,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic                              in_req_type,
  input  wire logic [CB_ADDR_W-1:0]              in_cb_addr,
  input  wire logic [WORD_W-1:0]                 in_cb_word,
  input  wire logic [7:0]                        in_index_low,
  input  wire logic [7:0]                        in_index_high,
  input  wire logic                              issue_ok,
  output issue_t                                 issue,
  output logic                                   mem_wr_en,
  output logic [$clog2(CODEBOOK_WORDS)-1:0]      mem_wr_addr,
  output logic [WORD_W-1:0]                      mem_wr_data,
  output logic                                   mem_rd_en,
  output logic [$clog2(CODEBOOK_WORDS)-1:0]      mem_rd_addr
);

  localparam int unsigned AW  = $clog2(CODEBOOK_WORDS);
  localparam int unsigned FAB = FRAME_ADDR_BITS;
  localparam logic [CA_W:0] CB_LIMIT = (CA_W+1)'(CODEBOOK_WORDS);

  logic               busy_r, busy_nxt;
  logic [1:0]         row_r, row_nxt;
  logic [1:0]         last_idx_r, last_idx_nxt;
  logic               fill_r, fill_nxt;
  logic [7:0]         lo_r, lo_nxt;
  logic [CA_W-1:0]    ca_r, ca_nxt;
  logic [FAB-1:0]     addr_r, addr_nxt;
  logic [COUNT_W-1:0] col_r, col_nxt;
  logic [COUNT_W-1:0] brow_r, brow_nxt;
  logic [FAB-1:0]     base_r, base_nxt;

  logic               accept, blk_acc, wr_acc, iss, last_now, oor_now;
  logic [7:0]         marker;
  logic [15:0]        in_index;
  logic [CA_W-1:0]    in_ca, wr_ca;
  logic [FAB-1:0]     pos_addr, stride_f, hs_f;
  logic [13:0]        hs;
  logic [COUNT_W-1:0] col_inc, brow_inc;

  assign marker   = cfg.block_mode ? MARKER_4X4 : MARKER_4X2;
  assign in_index = {in_index_high, in_index_low};
  assign in_ca    = cfg.block_mode ? {in_index, 2'b00} : {1'b0, in_index, 1'b0};
  assign stride_f = FAB'(cfg.line_stride);
  assign hs       = cfg.block_mode ? {cfg.line_stride, 2'b00} : {1'b0, cfg.line_stride, 1'b0};
  assign hs_f     = FAB'(hs);
  assign pos_addr = base_r + FAB'({col_r, 2'b00});
  assign col_inc  = col_r + 1'b1;
  assign brow_inc = brow_r + 1'b1;

  assign last_now  = (row_r == last_idx_r);
  assign in_tready = !busy_r || (issue_ok && last_now);
  assign accept    = in_tvalid && in_tready;
  assign blk_acc   = accept && (in_req_type == REQ_BLOCK);
  assign wr_acc    = accept && (in_req_type == REQ_CB_WRITE);
  assign iss       = busy_r && issue_ok;
  assign oor_now   = !fill_r && ({1'b0, ca_r} >= CB_LIMIT);

  assign wr_ca       = CA_W'(in_cb_addr);
  assign mem_wr_en   = wr_acc && ((CA_W+1)'(in_cb_addr) < CB_LIMIT);
  assign mem_wr_addr = wr_ca[AW-1:0];
  assign mem_wr_data = in_cb_word;
  assign mem_rd_en   = iss && !fill_r && !oor_now;
  assign mem_rd_addr = ca_r[AW-1:0];

  always_comb begin
    issue.valid     = iss;
    issue.byte_addr = BADDR_W'(addr_r);
    issue.last      = last_now;
    issue.oor       = oor_now;
    issue.fill      = fill_r;
    issue.fill_byte = lo_r;
  end

  always_comb begin
    busy_nxt     = busy_r;
    row_nxt      = row_r;
    last_idx_nxt = last_idx_r;
    fill_nxt     = fill_r;
    lo_nxt       = lo_r;
    ca_nxt       = ca_r;
    addr_nxt     = addr_r;
    col_nxt      = col_r;
    brow_nxt     = brow_r;
    base_nxt     = base_r;
    if (iss) begin
      row_nxt  = row_r + 1'b1;
      ca_nxt   = ca_r + 1'b1;
      addr_nxt = addr_r + stride_f;
      if (last_now) begin
        busy_nxt = 1'b0;
      end
    end
    if (blk_acc) begin
      busy_nxt     = 1'b1;
      row_nxt      = 2'd0;
      last_idx_nxt = cfg.block_mode ? 2'd3 : 2'd1;
      fill_nxt     = (in_index_high == marker);
      lo_nxt       = in_index_low;
      ca_nxt       = in_ca;
      addr_nxt     = pos_addr;
      if (col_inc >= cfg.frame_cols) begin
        col_nxt = '0;
        if (brow_inc >= cfg.block_rows) begin
          brow_nxt = '0;
          base_nxt = '0;
        end else begin
          brow_nxt = brow_inc;
          base_nxt = base_r + hs_f;
        end
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
      brow_r <= '0;
      base_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      col_r  <= col_nxt;
      brow_r <= brow_nxt;
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    last_idx_r <= last_idx_nxt;
    fill_r     <= fill_nxt;
    lo_r       <= lo_nxt;
    ca_r       <= ca_nxt;
    addr_r     <= addr_nxt;
  end

endmodule
`default_nettype wire

>>> sv/vqbd_out_stage.sv
// Read-data alignment stage and output register of the result stream.
`default_nettype none
module vqbd_out_stage
  import vqbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire issue_t            issue,
  input  wire logic [WORD_W-1:0] rd_data,
  output logic                   issue_ok,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [55:0]            out_tdata,
  output logic                   out_tlast,
  output logic [0:0]             out_tuser
);

  issue_t             s1_r;
  logic               s1_valid_r;
  logic               out_valid_r;
  logic [BADDR_W-1:0] out_addr_r;
  logic [WORD_W-1:0]  out_word_r;
  logic               out_last_r;
  logic               out_oor_r;
  logic               out_free;
  logic [WORD_W-1:0]  word;

  assign out_free = !out_valid_r || out_tready;
  assign issue_ok = !s1_valid_r || out_free;

  always_comb begin
    if (s1_r.fill) begin
      word = {4{s1_r.fill_byte}};
    end else if (s1_r.oor) begin
      word = '0;
    end else begin
      word = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue_ok) begin
        s1_valid_r <= issue.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_ok) begin
      s1_r <= issue;
    end
    if (out_free && s1_valid_r) begin
      out_addr_r <= s1_r.byte_addr;
      out_word_r <= word;
      out_last_r <= s1_r.last;
      out_oor_r  <= s1_r.oor;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_word_r, out_addr_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_oor_r;

endmodule
`default_nettype wire

>>> tb/vqbd_checker.sv
// Scoreboard for the VQ block decoder: predicts each block's row transfers and compares them.
`timescale 1ns / 100ps
module vqbd_checker
  import vqbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [63:0]           in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [55:0]           out_tdata,
  input  logic                  out_tlast,
  input  logic [0:0]            out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           rows_pending
);

  localparam longint unsigned FRAME_MASK = (64'd1 << FRAME_ADDR_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [BADDR_W-1:0] byte_addr;
    logic [WORD_W-1:0]  pixel_word;
    logic               last_row;
    logic               out_of_range;
  } pixel_row_t;

  pixel_row_t         rows_due[$];
  pixel_row_t         want;
  logic [WORD_W-1:0]  codebook [0:CODEBOOK_WORDS_DEF-1];
  cfg_t               regs;
  logic [COUNT_W-1:0] col_pos;
  logic [COUNT_W-1:0] row_pos;
  logic [BADDR_W-1:0] row_base;

  task automatic decode_block(input logic [7:0] lo, input logic [7:0] hi);
    int unsigned       height;
    int unsigned       r;
    logic [7:0]        marker;
    longint unsigned   cb_idx;
    longint unsigned   addr;
    longint unsigned   next_base;
    pixel_row_t        row;
    height = regs.block_mode ? 4 : 2;
    marker = regs.block_mode ? MARKER_4X4 : MARKER_4X2;
    for (r = 0; r < height; r++) begin
      addr = longint'(row_base) + 4 * longint'(col_pos) + longint'(r) * regs.line_stride;
      addr = addr & FRAME_MASK;
      row.byte_addr = addr[BADDR_W-1:0];
      row.last_row = (r + 1 == height);
      row.out_of_range = 1'b0;
      row.pixel_word = '0;
      if (hi == marker) begin
        row.pixel_word = {4{lo}};
      end else begin
        cb_idx = longint'({hi, lo}) * height + r;
        if (cb_idx < CODEBOOK_WORDS_DEF) begin
          row.pixel_word = codebook[cb_idx[CB_ADDR_W-1:0]];
        end else begin
          row.out_of_range = 1'b1;
        end
      end
      rows_due.push_back(row);
    end
    col_pos = col_pos + 1'b1;
    if (col_pos >= regs.frame_cols) begin
      col_pos = '0;
      next_base = (longint'(row_base) + longint'(height) * regs.line_stride) & FRAME_MASK;
      row_base = next_base[BADDR_W-1:0];
      row_pos = row_pos + 1'b1;
      if (row_pos >= regs.block_rows) begin
        row_pos = '0;
        row_base = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_due.delete();
      fail_count = 0;
      regs.block_mode = 1'b1;
      regs.frame_cols = 10'd80;
      regs.block_rows = 10'd50;
      regs.line_stride = 12'd320;
      col_pos = '0;
      row_pos = '0;
      row_base = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BLOCK_MODE:  regs.block_mode = cfg_data[0];
          CFG_FRAME_COLS:  regs.frame_cols = cfg_data[COUNT_W-1:0];
          CFG_BLOCK_ROWS:  regs.block_rows = cfg_data[COUNT_W-1:0];
          CFG_LINE_STRIDE: regs.line_stride = cfg_data[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (rows_due.size() == 0) begin
          $error("row transfer with no block pending: byte_addr %h", out_tdata[19:0]);
          fail_count++;
        end else begin
          want = rows_due.pop_front();
          if (out_tdata[19:0] !== want.byte_addr) begin
            $error("byte_addr expected %h got %h", want.byte_addr, out_tdata[19:0]);
            fail_count++;
          end
          if (out_tdata[51:20] !== want.pixel_word) begin
            $error("pixel_word expected %h got %h", want.pixel_word, out_tdata[51:20]);
            fail_count++;
          end
          if (out_tlast !== want.last_row) begin
            $error("last_row expected %b got %b", want.last_row, out_tlast);
            fail_count++;
          end
          if (out_tuser[0] !== want.out_of_range) begin
            $error("out_of_range expected %b got %b", want.out_of_range, out_tuser[0]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == REQ_CB_WRITE) begin
          if (32'(in_tdata[13:0]) < CODEBOOK_WORDS_DEF) begin
            codebook[in_tdata[13:0]] = in_tdata[45:14];
          end
        end else begin
          decode_block(in_tdata[53:46], in_tdata[61:54]);
        end
      end
    end
    rows_pending = rows_due.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the VQ block decoder testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module testbench;
  import vqbd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STUCK_LIMIT   = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [55:0]           out_tdata;
  logic                  out_tlast;
  logic [0:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned rows_pending;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  int unsigned stuck_cycles = 0;
  bit          quiet = 1'b0;
  logic        cur_mode = 1'b1;
  bit          cb_loaded [0:CODEBOOK_WORDS_DEF-1];

  vq_block_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  vqbd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 29);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic req, input logic [13:0] a, input logic [31:0] w,
                           input logic [7:0] lo, input logic [7:0] hi);
    int unsigned gap;
    gap = quiet ? 0 : gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {2'b00, hi, lo, w, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (req == REQ_CB_WRITE) cb_loaded[a] = 1'b1;
    items_sent++;
  endtask

  task automatic write_cb(input logic [13:0] a, input logic [31:0] w);
    send_item(REQ_CB_WRITE, a, w, 8'($urandom), 8'($urandom));
  endtask

  task automatic decode(input logic [7:0] lo, input logic [7:0] hi);
    send_item(REQ_BLOCK, 14'($urandom), $urandom, lo, hi);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic mode, input logic [COUNT_W-1:0] bpr,
                               input logic [COUNT_W-1:0] rows, input logic [STRIDE_W-1:0] stride);
    cfg_write(CFG_BLOCK_MODE, CFG_DATA_W'(mode));
    cfg_write(CFG_FRAME_COLS, CFG_DATA_W'(bpr));
    cfg_write(CFG_BLOCK_ROWS, CFG_DATA_W'(rows));
    cfg_write(CFG_LINE_STRIDE, CFG_DATA_W'(stride));
    cfg_valid <= 1'b0;
    cur_mode = mode;
  endtask

  // drop valid, wait out every pending row, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned kind;
    int unsigned height;
    int unsigned index;
    int unsigned r;
    int unsigned n_end;
    logic [7:0]  marker;
    height = cur_mode ? 4 : 2;
    marker = cur_mode ? MARKER_4X4 : MARKER_4X2;
    n_end = items_sent + n;
    while (items_sent < n_end) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        write_cb(14'($urandom), $urandom);
      end else if (kind < 25) begin
        decode(8'($urandom), marker);
      end else if (kind < 40) begin
        index = $urandom_range(CODEBOOK_WORDS_DEF / height, 16'hFFFF);
        decode(index[7:0], index[15:8]);
      end else begin
        if (kind < 70) index = $urandom_range(0, 15);
        else index = $urandom_range(0, CODEBOOK_WORDS_DEF / height - 1);
        // load any row of the block not yet written, and refresh some at random
        for (r = 0; r < height; r++) begin
          if (!cb_loaded[index * height + r] || $urandom_range(0, 3) == 0) begin
            write_cb(14'(index * height + r), $urandom);
          end
        end
        decode(index[7:0], index[15:8]);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: 4x4 blocks
    write_cb(14'd0, 32'h0000_0000);
    write_cb(14'd1, 32'hFFFF_FFFF);
    write_cb(14'd2, 32'hA5A5_5A5A);
    write_cb(14'd3, 32'h0123_4567);
    decode(8'h00, 8'h00);
    write_cb(14'd16380, 32'hFFFF_FFFF);
    write_cb(14'd16381, 32'h8000_0001);
    write_cb(14'd16382, 32'h7FFF_FFFE);
    write_cb(14'd16383, 32'hDEAD_BEEF);
    decode(8'hFF, 8'h0F);
    decode(8'h00, 8'hFF);
    decode(8'hFF, 8'hFF);
    decode(8'h00, 8'h10);
    decode(8'hFF, 8'hFE);
    drain();

    load_settings(1'b0, 10'd80, 10'd50, 12'd320);
    decode(8'h3C, 8'h0F);
    decode(8'h00, 8'h0F);
    decode(8'hFF, 8'h1F);
    decode(8'h01, 8'h00);
    decode(8'hFF, 8'hFF);
    decode(8'h00, 8'h20);
    drain();

    load_settings(1'b0, 10'd3, 10'd2, 12'd4);
    run_phase(40);
    drain();

    load_settings(1'b1, 10'd1, 10'd1023, 12'd4095);
    run_phase(90);
    drain();

    quiet = 1'b1;
    load_settings(1'b0, 10'd1023, 10'd1023, 12'd4095);
    run_phase(40);
    drain();
    quiet = 1'b0;

    load_settings(1'b1, 10'd0, 10'd0, 12'd100);
    run_phase(40);
    drain();

    load_settings(1'($urandom), 10'($urandom_range(1, 6)), 10'($urandom_range(1, 4)),
                  12'($urandom_range(4, 4095)));
    run_phase(40);
    drain();

    load_settings(1'b1, 10'd80, 10'd50, 12'd320);
    run_phase(40);
    drain();

    if (fail_count == 0 && rows_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/vqbd_pkg.sv
sv/vqbd_codebook_mem.sv
sv/vqbd_sequencer.sv
sv/vqbd_out_stage.sv
sv/vq_block_decoder_top.sv
tb/vqbd_checker.sv
tb/testbench.sv
